@@ rtl/tia_pkg.sv @@
// ----------------------------------------------------------------------------
// tia_pkg
// Shared types and constants for the tagged integer ALU.
// ----------------------------------------------------------------------------
package tia_pkg;

  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned OpWidth      = 4;
  localparam int unsigned KindWidth    = 2;
  localparam int unsigned OutcomeWidth = 3;
  localparam int unsigned ShiftBits    = 5;
  localparam int unsigned QueueDepth   = 4;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_MOD = 4'd4, OP_AND = 4'd5, OP_OR  = 4'd6, OP_XOR = 4'd7,
    OP_SHL = 4'd8, OP_SHR = 4'd9, OP_EQ  = 4'd10, OP_NE = 4'd11,
    OP_LT  = 4'd12, OP_LE = 4'd13, OP_GT = 4'd14, OP_GE = 4'd15
  } op_e;

  typedef enum logic [KindWidth-1:0] {
    KIND_NUM = 2'd0, KIND_ERA = 2'd1, KIND_SUP = 2'd2, KIND_OTH = 2'd3
  } kind_e;

  typedef enum logic [OutcomeWidth-1:0] {
    OUT_NUM = 3'd0, OUT_ERA = 3'd1, OUT_DIST_A = 3'd2,
    OUT_DIST_B = 3'd3, OUT_BAD_A = 3'd4, OUT_BAD_B = 3'd5
  } outcome_e;

endpackage

@@ rtl/tagged_integer_alu.sv @@
// ----------------------------------------------------------------------------
// tagged_integer_alu
// Tagged two-operand integer ALU with queue-style ports on both sides.
// ----------------------------------------------------------------------------
// Channel  Handshake   Fields
// input    push/full   action, a_kind, a_value, b_kind, b_value
// result   empty/pop   outcome, result_value
//
// One item per cycle sustained while pop keeps up. Each item crosses the
// queue's registered RAM read, then the pipelined divider, one quotient
// bit per stage, then the output register.
// Reset clears the queue pointers and pipeline valid bits.
// A stalled pop freezes the back pipeline; the queue then absorbs up to four
// items before full rises.
module tagged_integer_alu
  import tia_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  action_i,
  input  logic [1:0]  a_kind_i,
  input  logic [31:0] a_value_i,
  input  logic [1:0]  b_kind_i,
  input  logic [31:0] b_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  outcome_o,
  output logic [31:0] result_value_o
);
  localparam int unsigned QW = OutcomeWidth + OpWidth + 2*DATA_WIDTH;

  outcome_e              f_oc;
  op_e                   f_op;
  logic [DATA_WIDTH-1:0] f_x, f_y;
  logic [QW-1:0]         q_in, q_out;
  logic                  q_valid, b_ready, out_valid;

  tia_front #(.DataWidth(DATA_WIDTH)) u_front (
    .action_i, .a_kind_i, .a_value_i, .b_kind_i, .b_value_i,
    .outcome_o(f_oc), .op_o(f_op), .x_o(f_x), .y_o(f_y)
  );

  assign q_in = {f_oc, f_op, f_x, f_y};

  tia_queue #(.Width(QW)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(q_in), .full_o(full),
    .valid_o(q_valid), .ready_i(b_ready), .rdata_o(q_out)
  );

  tia_back #(.DataWidth(DATA_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(b_ready),
    .outcome_i(outcome_e'(q_out[QW-1 -: OutcomeWidth])),
    .op_i(op_e'(q_out[2*DATA_WIDTH +: OpWidth])),
    .x_i(q_out[DATA_WIDTH +: DATA_WIDTH]),
    .y_i(q_out[DATA_WIDTH-1:0]),
    .out_valid_o(out_valid), .out_ready_i(pop),
    .outcome_o, .result_value_o
  );

  assign empty = !out_valid;
endmodule

@@ rtl/tia_ram.sv @@
// ----------------------------------------------------------------------------
// tia_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tia_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/tia_front.sv @@
// ----------------------------------------------------------------------------
// tia_front
// Classifies operand kinds, picks the outcome and forwards work to the queue.
// ----------------------------------------------------------------------------
module tia_front
  import tia_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  logic [OpWidth-1:0]   action_i,
  input  logic [KindWidth-1:0] a_kind_i,
  input  logic [31:0]          a_value_i,
  input  logic [KindWidth-1:0] b_kind_i,
  input  logic [31:0]          b_value_i,
  output outcome_e             outcome_o,
  output op_e                  op_o,
  output logic [DataWidth-1:0] x_o,
  output logic [DataWidth-1:0] y_o
);
  // Operands are taken modulo 2^DataWidth.
  logic [63:0] a_ext, b_ext;
  assign a_ext = {32'd0, a_value_i};
  assign b_ext = {32'd0, b_value_i};
  assign x_o   = a_ext[DataWidth-1:0];
  assign y_o   = b_ext[DataWidth-1:0];
  assign op_o  = op_e'(action_i);

  always_comb begin
    case (kind_e'(a_kind_i))
      KIND_ERA: outcome_o = OUT_ERA;
      KIND_SUP: outcome_o = OUT_DIST_A;
      KIND_OTH: outcome_o = OUT_BAD_A;
      default: begin
        case (kind_e'(b_kind_i))
          KIND_ERA: outcome_o = OUT_ERA;
          KIND_SUP: outcome_o = OUT_DIST_B;
          KIND_OTH: outcome_o = OUT_BAD_B;
          default:  outcome_o = OUT_NUM;
        endcase
      end
    endcase
  end
endmodule

@@ rtl/tia_divider.sv @@
// ----------------------------------------------------------------------------
// tia_divider
// Pipelined restoring divider, one quotient bit per stage; zero divisor -> 0.
// ----------------------------------------------------------------------------
module tia_divider #(
  parameter int unsigned DataWidth = 32,
  parameter int unsigned TagWidth  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [DataWidth-1:0] x_i,
  input  logic [DataWidth-1:0] y_i,
  input  logic [TagWidth-1:0]  tag_i,
  output logic [DataWidth-1:0] quo_o,
  output logic [DataWidth-1:0] rem_o,
  output logic [TagWidth-1:0]  tag_o
);
  for (genvar s = 0; s < DataWidth; s++) begin : g_stage
    logic [DataWidth-1:0] rem_in, quo_in, dvs_in;
    logic [TagWidth-1:0]  tag_in;
    logic [DataWidth-1:0] rem_q, quo_q, dvs_q;
    logic [TagWidth-1:0]  tag_q;
    logic [DataWidth:0]   trial;
    logic [DataWidth:0]   diff;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = x_i;
      assign dvs_in = y_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = g_stage[s-1].rem_q;
      assign quo_in = g_stage[s-1].quo_q;
      assign dvs_in = g_stage[s-1].dvs_q;
      assign tag_in = g_stage[s-1].tag_q;
    end

    assign trial = {rem_in, quo_in[DataWidth-1]};
    assign diff  = trial - {1'b0, dvs_in};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= diff[DataWidth] ? trial[DataWidth-1:0] : diff[DataWidth-1:0];
        quo_q <= {quo_in[DataWidth-2:0], ~diff[DataWidth]};
        dvs_q <= dvs_in;
        tag_q <= tag_in;
      end
    end
  end

  logic zero_div;
  assign zero_div = (g_stage[DataWidth-1].dvs_q == '0);
  assign quo_o = zero_div ? '0 : g_stage[DataWidth-1].quo_q;
  assign rem_o = zero_div ? '0 : g_stage[DataWidth-1].rem_q;
  assign tag_o = g_stage[DataWidth-1].tag_q;

  logic unused_rst;
  assign unused_rst = rst_ni;
endmodule

@@ rtl/tia_back.sv @@
// ----------------------------------------------------------------------------
// tia_back
// Execution pipeline: stalls as a whole when its output register is full and not drained.
// ----------------------------------------------------------------------------
module tia_back
  import tia_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  outcome_e             outcome_i,
  input  op_e                  op_i,
  input  logic [DataWidth-1:0] x_i,
  input  logic [DataWidth-1:0] y_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OutcomeWidth-1:0] outcome_o,
  output logic [31:0]          result_value_o
);
  localparam int unsigned Stages  = DataWidth + 1;
  localparam int unsigned TagW    = 1 + OutcomeWidth + OpWidth + DataWidth;

  // Stage 0 computes the simple ops; the divider carries them along as a tag.
  logic                 adv;
  logic [Stages-1:0]    vld_q, vld_d;
  logic [DataWidth-1:0] simple;
  logic [2*DataWidth-1:0] prod;
  logic [TagW-1:0]      tag_in, tag_out;
  logic [DataWidth-1:0] quo, rem;
  logic [ShiftBits-1:0] sh;

  assign prod = x_i * y_i;
  assign sh   = y_i[ShiftBits-1:0];

  always_comb begin
    case (op_i)
      OP_ADD:  simple = x_i + y_i;
      OP_SUB:  simple = x_i - y_i;
      OP_MUL:  simple = prod[DataWidth-1:0];
      OP_AND:  simple = x_i & y_i;
      OP_OR:   simple = x_i | y_i;
      OP_XOR:  simple = x_i ^ y_i;
      OP_SHL:  simple = x_i << sh;
      OP_SHR:  simple = x_i >> sh;
      OP_EQ:   simple = DataWidth'(x_i == y_i);
      OP_NE:   simple = DataWidth'(x_i != y_i);
      OP_LT:   simple = DataWidth'(x_i < y_i);
      OP_LE:   simple = DataWidth'(x_i <= y_i);
      OP_GT:   simple = DataWidth'(x_i > y_i);
      OP_GE:   simple = DataWidth'(x_i >= y_i);
      default: simple = '0;
    endcase
  end

  assign tag_in = {in_valid_i, outcome_i, op_i, simple};

  // Output register; pipeline moves when it is empty or being drained.
  logic                    ov_q;
  logic [OutcomeWidth-1:0] oc_q;
  logic [31:0]             ov_val_q;
  assign adv        = !ov_q || out_ready_i;
  assign in_ready_o = adv;

  tia_divider #(.DataWidth(DataWidth), .TagWidth(TagW)) u_div (
    .clk_i, .rst_ni, .en_i(adv), .x_i, .y_i, .tag_i(tag_in),
    .quo_o(quo), .rem_o(rem), .tag_o(tag_out)
  );

  assign vld_d = {vld_q[Stages-2:0], in_valid_i};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  logic                 last_vld;
  outcome_e             t_oc;
  op_e                  t_op;
  logic [DataWidth-1:0] t_val, fin;
  logic [63:0]          fin_ext;
  assign last_vld = vld_q[Stages-2];
  assign t_oc  = outcome_e'(tag_out[TagW-2 -: OutcomeWidth]);
  assign t_op  = op_e'(tag_out[DataWidth +: OpWidth]);
  assign t_val = tag_out[DataWidth-1:0];

  always_comb begin
    case (t_op)
      OP_DIV:  fin = quo;
      OP_MOD:  fin = rem;
      default: fin = t_val;
    endcase
    if (t_oc != OUT_NUM) fin = '0;
  end
  assign fin_ext = {{(64-DataWidth){1'b0}}, fin};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= last_vld && tag_out[TagW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oc_q     <= t_oc;
      ov_val_q <= fin_ext[31:0];
    end
  end

  assign out_valid_o    = ov_q;
  assign outcome_o      = oc_q;
  assign result_value_o = ov_val_q;

  logic unused;
  assign unused = vld_q[Stages-1] ^ ^prod[2*DataWidth-1:DataWidth];
endmodule

@@ rtl/tia_queue.sv @@
// ----------------------------------------------------------------------------
// tia_queue
// Short FIFO between front and back, stored in the generic RAM.
// ----------------------------------------------------------------------------
module tia_queue
  import tia_pkg::*;
#(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] rdata_o
);
  localparam int unsigned AW = $clog2(QueueDepth);

  logic [AW:0]   wp_q, rp_q, rp_d;
  logic [AW:0]   cnt, occ;
  logic          ov_q, take;
  logic [AW-1:0] raddr;
  logic [Width-1:0] ram_q;

  // The RAM read is registered: fetch ahead into the output slot.
  // The held item keeps its RAM entry until it leaves, so count it as stored.
  assign cnt    = wp_q - rp_q;
  assign occ    = cnt + {{AW{1'b0}}, ov_q};
  assign full_o = (occ == (AW+1)'(QueueDepth));
  assign take   = (cnt != '0) && (!ov_q || ready_i);
  assign rp_d   = take ? rp_q + 1'b1 : rp_q;
  // Re-read the held entry while it waits.
  assign raddr  = take ? rp_q[AW-1:0] : rp_q[AW-1:0] - 1'b1;

  tia_ram #(.Width(Width), .Depth(QueueDepth)) u_ram (
    .clk_i, .we_i(push_i && !full_o), .waddr_i(wp_q[AW-1:0]), .wdata_i,
    .raddr_i(raddr), .rdata_o(ram_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (push_i && !full_o) wp_q <= wp_q + 1'b1;
      rp_q <= rp_d;
      if (take) ov_q <= 1'b1;
      else if (ready_i) ov_q <= 1'b0;
    end
  end

  assign valid_o = ov_q;
  assign rdata_o = ram_q;
endmodule

@@ rtl/tia_checker.sv @@
// ----------------------------------------------------------------------------
// tia_checker
// Port-level checks on the tagged integer ALU.
// ----------------------------------------------------------------------------
module tia_checker
  import tia_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  outcome_o,
  input logic [31:0] result_value_o
);
  // Held result keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(outcome_o) && $stable(result_value_o))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> outcome_o <= OUT_BAD_B)
    else $error("outcome out of range");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && outcome_o != OUT_NUM |-> result_value_o == '0)
    else $error("nonzero value for non-number outcome");

  a_rst: assert property (@(posedge clk_i) !rst_ni |-> empty && !full)
    else $error("not empty in reset");
endmodule

bind tagged_integer_alu tia_checker u_checker (.*);
